// File: design/pfdp_pkg.sv
// ----------------------------------------------------------------------------
// pfdp_pkg
// Shared types and constants of the per-flow departure time pacer.
// ----------------------------------------------------------------------------
package pfdp_pkg;

  // Flow store geometry.
  localparam int unsigned FLOW_COUNT = 1024;
  localparam int unsigned FLOW_W     = $clog2(FLOW_COUNT);
  localparam int unsigned FLOW_IDX_W = 10;

  // Field widths.
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned RATE_W  = 32;
  localparam int unsigned DELAY_W = 23;

  // Nanoseconds of serialization per unit of packet length at one kilobit per second.
  localparam int unsigned LEN_SCALE  = 1000000;
  localparam int unsigned NS_IN_US   = 1000;
  // length * LEN_SCALE stays below 2^36; delay * NS_IN_US below 2^33.
  localparam int unsigned DIVIDEND_W = 36;
  localparam int unsigned EXTRA_W    = 33;

  // The divider retires one quotient bit per cycle.
  localparam int unsigned DIV_STEPS = DIVIDEND_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned CNT_W     = (FLOW_W > DIV_CNT_W) ? FLOW_W : DIV_CNT_W;

  // Flow store entry: valid flag on top of the stored departure time.
  localparam int unsigned ENTRY_W = TIME_W + 1;

  // Register file.
  localparam int unsigned  PADDR_W     = 4;
  localparam int unsigned  PDATA_W     = 64;
  localparam int unsigned  REG_SEL_BIT = 3;
  localparam logic [63:0]  DROP_HORIZON_RESET = 64'd2000000000;
  localparam logic [63:0]  ECN_HORIZON_RESET  = 64'd999999000000;

  typedef enum logic {
    REG_DROP_HORIZON = 1'b0,
    REG_ECN_HORIZON  = 1'b1
  } reg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              step;
    logic              calc;
    logic              decide;
    logic              finish;
    logic              clr_we;
    logic [FLOW_W-1:0] clr_addr;
  } pfdp_cmd_t;

endpackage

// File: design/pfdp_ram.sv
// ----------------------------------------------------------------------------
// pfdp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfdp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/pfdp_ctrl.sv
// ----------------------------------------------------------------------------
// pfdp_ctrl
// Sequencer: clears the flow store after reset, then steps each packet
// through load, divide, compute, decide and finish.
// ----------------------------------------------------------------------------
module pfdp_ctrl
  import pfdp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  output pfdp_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DIV    = 6'b000100,
    S_CALC   = 6'b001000,
    S_DECIDE = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we   = 1'b1;
        cmd_o.clr_addr = cnt_q[FLOW_W-1:0];
        if (cnt_q == CNT_W'(FLOW_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_CALC;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// File: design/pfdp_dp.sv
// ----------------------------------------------------------------------------
// pfdp_dp
// Datapath: request registers, bit-serial divider, flow store and the
// departure time decision.
// ----------------------------------------------------------------------------
module pfdp_dp
  import pfdp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pfdp_cmd_t             cmd_i,
  input  logic [FLOW_IDX_W-1:0] flow_index_i,
  input  logic [LEN_W-1:0]      packet_length_i,
  input  logic [TIME_W-1:0]     packet_time_i,
  input  logic [TIME_W-1:0]     now_time_i,
  input  logic [RATE_W-1:0]     rate_kbps_i,
  input  logic [DELAY_W-1:0]    delay_us_i,
  input  logic [TIME_W-1:0]     drop_horizon_i,
  input  logic [TIME_W-1:0]     ecn_horizon_i,
  output logic                  done_o,
  output logic                  drop_o,
  output logic                  ecn_mark_o,
  output logic [TIME_W-1:0]     departure_time_o
);

  // Request registers.
  logic [FLOW_W-1:0]     flow_q;
  logic [TIME_W-1:0]     pkt_q, now_q;
  logic [RATE_W-1:0]     divisor_q;
  logic                  rate_zero_q;
  logic [DELAY_W-1:0]    delay_q;

  // Divider state.
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [RATE_W-1:0]     rem_q, rem_d;
  logic [RATE_W:0]       rem_sh;
  logic [RATE_W+1:0]     rem_diff;

  // Intermediate results.
  logic [TIME_W-1:0]     next_q, floor_q;
  logic [EXTRA_W-1:0]    extra_q;
  logic                  drop_q, mark_q;
  logic [TIME_W-1:0]     dep_pre_q, store_q;

  logic [FLOW_W-1:0]     flow_d;
  logic [DIVIDEND_W-1:0] dividend;
  logic [ENTRY_W-1:0]    rdata;
  logic                  first_path;
  logic [TIME_W-1:0]     lead;
  logic                  over_drop, over_ecn;
  logic [TIME_W-1:0]     dep_base;

  logic                  ram_we;
  logic [FLOW_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;

  logic                  done_q;
  logic                  drop_out_q, mark_out_q;
  logic [TIME_W-1:0]     dep_out_q;

  assign flow_d   = FLOW_W'(32'(flow_index_i) % FLOW_COUNT);
  assign dividend = DIVIDEND_W'(packet_length_i) * DIVIDEND_W'(LEN_SCALE);

  // Restoring division, one quotient bit per step.
  always_comb begin
    rem_sh   = {rem_q, quo_q[DIVIDEND_W-1]};
    rem_diff = {1'b0, rem_sh} - {2'b00, divisor_q};
    if (!rem_diff[RATE_W+1]) begin
      rem_d = rem_diff[RATE_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[RATE_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], 1'b0};
    end
  end

  assign first_path = (next_q <= floor_q);
  assign lead       = next_q - now_q;
  assign over_drop  = (lead >= drop_horizon_i);
  assign over_ecn   = (lead >= ecn_horizon_i);
  assign dep_base   = (dep_pre_q == '0) ? now_q : dep_pre_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      flow_q      <= flow_d;
      pkt_q       <= packet_time_i;
      now_q       <= now_time_i;
      divisor_q   <= rate_kbps_i;
      rate_zero_q <= (rate_kbps_i == '0);
      delay_q     <= delay_us_i;
      quo_q       <= dividend;
      rem_q       <= '0;
    end else if (cmd_i.step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (cmd_i.calc) begin
      next_q  <= rdata[ENTRY_W-1] ? rdata[TIME_W-1:0] + TIME_W'(quo_q) : '0;
      floor_q <= (pkt_q < now_q) ? now_q : pkt_q;
      extra_q <= EXTRA_W'(delay_q) * EXTRA_W'(NS_IN_US);
    end
    if (cmd_i.decide) begin
      drop_q    <= rate_zero_q || (!first_path && over_drop);
      mark_q    <= !rate_zero_q && !first_path && !over_drop && over_ecn;
      dep_pre_q <= first_path ? pkt_q : next_q;
      store_q   <= first_path ? floor_q : next_q;
    end
    if (cmd_i.finish) begin
      drop_out_q <= drop_q;
      mark_out_q <= mark_q;
      dep_out_q  <= drop_q ? '0 : dep_base + TIME_W'(extra_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  // Flow store: the clearing pass writes invalid entries, a passed packet
  // writes its flow's new departure time.
  assign ram_we    = cmd_i.clr_we || (cmd_i.finish && !drop_q);
  assign ram_waddr = cmd_i.clr_we ? cmd_i.clr_addr : flow_q;
  assign ram_wdata = cmd_i.clr_we ? '0 : {1'b1, store_q};

  pfdp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FLOW_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.load),
    .raddr_i (flow_d),
    .rdata_o (rdata)
  );

  assign done_o           = done_q;
  assign drop_o           = drop_out_q;
  assign ecn_mark_o       = mark_out_q;
  assign departure_time_o = dep_out_q;

endmodule

// File: design/per_flow_departure_time_pacer_unit.sv
// ----------------------------------------------------------------------------
// per_flow_departure_time_pacer_unit
// Earliest-departure-time pacer with a per-flow departure time store.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising clock edge where start is high and busy
//   is low. It carries the flow index, packet length, packet timestamp,
//   current time, flow rate and added delay. Exactly one result follows:
//   drop, ecn_mark and departure_time, shown for one cycle with done_o high.
//   The receiver cannot hold a result off; it must take it in that cycle.
//   Busy drops in the cycle the result is shown, so a new request may be
//   accepted then; the block takes no new request while one is in flight.
//   The request is loaded and its flow looked up, then the serialization
//   delay divider retires one quotient bit of the 36-bit dividend per
//   cycle, and the block then computes, decides and registers the result.
//   After reset the flow store is swept clear, one entry per cycle, with
//   busy high. The horizon registers sit on the APB port at byte
//   addresses 0 (drop horizon) and 8 (ECN horizon), are 64 bits wide, and
//   may be written at any time, even during the clearing sweep, but only
//   take effect reliably while no request is in flight.
// ----------------------------------------------------------------------------
module per_flow_departure_time_pacer_unit
  import pfdp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request channel.
  input  logic                  start,
  output logic                  busy,
  input  logic [FLOW_IDX_W-1:0] flow_index_i,
  input  logic [LEN_W-1:0]      packet_length_i,
  input  logic [TIME_W-1:0]     packet_time_i,
  input  logic [TIME_W-1:0]     now_time_i,
  input  logic [RATE_W-1:0]     rate_kbps_i,
  input  logic [DELAY_W-1:0]    delay_us_i,
  // Result channel.
  output logic                  done_o,
  output logic                  drop_o,
  output logic                  ecn_mark_o,
  output logic [TIME_W-1:0]     departure_time_o,
  // Register port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  pfdp_cmd_t         cmd;
  logic [TIME_W-1:0] drop_hz_q, ecn_hz_q;
  logic              reg_wr;
  logic              sel_ecn;

  // The register port never waits. The low address bits are the byte
  // offset inside a 64-bit register, so only the register select bit is
  // decoded.
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign sel_ecn = (paddr[REG_SEL_BIT] == REG_ECN_HORIZON);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_hz_q <= DROP_HORIZON_RESET;
      ecn_hz_q  <= ECN_HORIZON_RESET;
    end else if (reg_wr) begin
      if (sel_ecn) begin
        ecn_hz_q <= pwdata;
      end else begin
        drop_hz_q <= pwdata;
      end
    end
  end

  assign prdata = sel_ecn ? ecn_hz_q : drop_hz_q;

  // The controller sequences the clearing sweep and each request; the
  // datapath holds the divider, the flow store and the result registers.
  pfdp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  pfdp_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .flow_index_i     (flow_index_i),
    .packet_length_i  (packet_length_i),
    .packet_time_i    (packet_time_i),
    .now_time_i       (now_time_i),
    .rate_kbps_i      (rate_kbps_i),
    .delay_us_i       (delay_us_i),
    .drop_horizon_i   (drop_hz_q),
    .ecn_horizon_i    (ecn_hz_q),
    .done_o           (done_o),
    .drop_o           (drop_o),
    .ecn_mark_o       (ecn_mark_o),
    .departure_time_o (departure_time_o)
  );

endmodule

// File: design/pfdp_checker.sv
// ----------------------------------------------------------------------------
// pfdp_checker
// Port-level checks of the pacer's request and result timing and of its dropped results.
// ----------------------------------------------------------------------------
module pfdp_checker
  import pfdp_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  done_o,
  input logic                  drop_o,
  input logic                  ecn_mark_o,
  input logic [TIME_W-1:0]     departure_time_o
);

  // Every request that is taken is followed by a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##40 done_o)
    else $error("result did not arrive 40 cycles after its request");

  // The pacer is busy right after it takes a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("not busy after accepting a request");

  // A result is shown for one cycle only, and the block is free again then.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy ##1 !done_o)
    else $error("result strobe longer than one cycle or block still busy");

  // A dropped packet is never marked and has no departure time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && drop_o) |-> (!ecn_mark_o && departure_time_o == '0))
    else $error("dropped packet carries a mark or a departure time");

endmodule

bind per_flow_departure_time_pacer_unit pfdp_checker u_pfdp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .drop_o           (drop_o),
  .ecn_mark_o       (ecn_mark_o),
  .departure_time_o (departure_time_o)
);

// File: bench/tb_per_flow_departure_time_pacer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_flow_departure_time_pacer_unit
// Self-checking bench for the per-flow departure time pacer. The bench keeps
// its own model of the flow store and the two horizon registers. Each
// accepted request is turned into an expected verdict. Each strobed result
// is checked against the oldest expected verdict. Directed requests come
// first, then random traffic under several horizon settings and gap rates.
// ----------------------------------------------------------------------------
module tb_per_flow_departure_time_pacer_unit;
  import pfdp_pkg::*;

  // Run length guard, in clock cycles. It leaves a wide margin over the
  // slowest correct run, about the clearing sweep plus 1500 requests,
  // each followed by the longest gap.
  localparam int unsigned CYCLE_LIMIT      = 1000000;
  // Cycles allowed after the last result before the verdict is printed.
  localparam int unsigned TAIL_CYCLES      = 60;
  localparam int unsigned PHASE_COUNT      = 6;
  localparam int unsigned REQS_PER_PHASE   = 250;
  localparam int unsigned MAX_GAP          = 45;
  localparam int unsigned MAX_PRINTED      = 100;
  localparam logic [63:0] NS_PER_KB_KBPS   = 64'd1000000;
  localparam logic [63:0] USEC_SCALE       = 64'd1000;
  localparam logic [63:0] TIME_MAX         = '1;

  // One expected result of the pacer.
  typedef struct packed {
    logic              drop;
    logic              ecn_mark;
    logic [TIME_W-1:0] departure_time;
  } departure_verdict_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the flow store and the horizons, predicts a verdict
  // for every accepted request and checks results in order.
  // --------------------------------------------------------------------------
  class departure_scoreboard;
    logic [TIME_W-1:0]  drop_horizon;
    logic [TIME_W-1:0]  ecn_horizon;
    logic [TIME_W-1:0]  stored_departure [FLOW_COUNT];
    bit                 flow_seen [FLOW_COUNT];
    departure_verdict_t pending_verdicts [$];
    int unsigned        error_count;

    function new();
      drop_horizon = DROP_HORIZON_RESET;
      ecn_horizon  = ECN_HORIZON_RESET;
      error_count  = 0;
      foreach (flow_seen[i]) begin
        flow_seen[i]        = 1'b0;
        stored_departure[i] = '0;
      end
    endfunction

    function int unsigned pending();
      return pending_verdicts.size();
    endfunction

    // Works out the verdict of one accepted request and updates the store
    // the same way the block is meant to.
    function void note_request(logic [FLOW_IDX_W-1:0] flow, logic [LEN_W-1:0] len,
                               logic [TIME_W-1:0] pkt_time, logic [TIME_W-1:0] now,
                               logic [RATE_W-1:0] rate, logic [DELAY_W-1:0] delay);
      int unsigned        slot;
      logic [TIME_W-1:0]  serial_ns;
      logic [TIME_W-1:0]  extra_ns;
      logic [TIME_W-1:0]  next_ns;
      logic [TIME_W-1:0]  floor_ns;
      logic [TIME_W-1:0]  lead_ns;
      logic [TIME_W-1:0]  dep_ns;
      departure_verdict_t verdict;
      slot    = int'(flow) % FLOW_COUNT;
      verdict = '0;
      // A zero rate drops the packet and leaves the store alone.
      if (rate == '0) begin
        verdict.drop = 1'b1;
        pending_verdicts.push_back(verdict);
        return;
      end
      serial_ns = (64'(len) * NS_PER_KB_KBPS) / 64'(rate);
      extra_ns  = 64'(delay) * USEC_SCALE;
      next_ns   = flow_seen[slot] ? stored_departure[slot] + serial_ns : '0;
      floor_ns  = (pkt_time < now) ? now : pkt_time;
      if (next_ns <= floor_ns) begin
        stored_departure[slot] = floor_ns;
        flow_seen[slot]        = 1'b1;
        dep_ns                 = pkt_time;
      end else begin
        lead_ns = next_ns - now;
        if (lead_ns >= drop_horizon) begin
          verdict.drop = 1'b1;
          pending_verdicts.push_back(verdict);
          return;
        end
        verdict.ecn_mark       = (lead_ns >= ecn_horizon);
        stored_departure[slot] = next_ns;
        dep_ns                 = next_ns;
      end
      // An unset packet time takes the added delay from the current time.
      verdict.departure_time = (dep_ns == '0) ? now + extra_ns : dep_ns + extra_ns;
      pending_verdicts.push_back(verdict);
    endfunction

    task report_mismatch(string what, logic [63:0] wanted, logic [63:0] seen);
      error_count++;
      if (error_count <= MAX_PRINTED)
        $display("[%0t] pacer check failed: %s expected %h got %h",
                 $realtime, what, wanted, seen);
    endtask

    task check_result(logic drop, logic ecn_mark, logic [TIME_W-1:0] departure_time);
      departure_verdict_t wanted;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result without request", '0, 64'(drop));
        return;
      end
      wanted = pending_verdicts.pop_front();
      if (drop !== wanted.drop)
        report_mismatch("drop", 64'(wanted.drop), 64'(drop));
      if (ecn_mark !== wanted.ecn_mark)
        report_mismatch("ecn_mark", 64'(wanted.ecn_mark), 64'(ecn_mark));
      if (departure_time !== wanted.departure_time)
        report_mismatch("departure_time", wanted.departure_time, departure_time);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block under test.
  // --------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [FLOW_IDX_W-1:0] flow_index_i;
  logic [LEN_W-1:0]      packet_length_i;
  logic [TIME_W-1:0]     packet_time_i;
  logic [TIME_W-1:0]     now_time_i;
  logic [RATE_W-1:0]     rate_kbps_i;
  logic [DELAY_W-1:0]    delay_us_i;
  logic                  done_o;
  logic                  drop_o;
  logic                  ecn_mark_o;
  logic [TIME_W-1:0]     departure_time_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [PDATA_W-1:0]    pwdata;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  departure_scoreboard sb = new();

  // Simulated wall clock that random requests draw their current time from.
  logic [TIME_W-1:0] wall_ns;
  int unsigned       cycle_count;

  per_flow_departure_time_pacer_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .flow_index_i     (flow_index_i),
    .packet_length_i  (packet_length_i),
    .packet_time_i    (packet_time_i),
    .now_time_i       (now_time_i),
    .rate_kbps_i      (rate_kbps_i),
    .delay_us_i       (delay_us_i),
    .done_o           (done_o),
    .drop_o           (drop_o),
    .ecn_mark_o       (ecn_mark_o),
    .departure_time_o (departure_time_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 4 ns clock period.
  always #2 clk_i = ~clk_i;

  // Monitor. Inputs change only through nonblocking assignments at the
  // rising edge, so at the edge every signal read here still holds the value
  // the block itself sees. The result is checked before the request of the
  // same edge is noted, so a new request can never be matched against a
  // result that belongs to an older one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        sb.check_result(drop_o, ecn_mark_o, departure_time_o);
      if (start && !busy)
        sb.note_request(flow_index_i, packet_length_i, packet_time_i, now_time_i,
                        rate_kbps_i, delay_us_i);
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("per_flow_departure_time_pacer_unit: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver tasks. Each one is entered right after a rising edge and returns
  // right after one, so its first assignments land on that edge.
  // --------------------------------------------------------------------------

  // Presents one request and holds it until the edge that accepts it. The
  // request strobe is left high; the caller lowers it if a gap follows.
  task automatic send_request(input logic [FLOW_IDX_W-1:0] flow,
                              input logic [LEN_W-1:0]      len,
                              input logic [TIME_W-1:0]     pkt_time,
                              input logic [TIME_W-1:0]     now,
                              input logic [RATE_W-1:0]     rate,
                              input logic [DELAY_W-1:0]    delay);
    start           <= 1'b1;
    flow_index_i    <= flow;
    packet_length_i <= len;
    packet_time_i   <= pkt_time;
    now_time_i      <= now;
    rate_kbps_i     <= rate;
    delay_us_i      <= delay;
    do @(posedge clk_i); while (busy);
  endtask

  // Writes one horizon register with a setup and an access cycle, then
  // brings the scoreboard copy in line at the edge that commits it.
  task automatic write_horizon(input reg_idx_e idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << REG_SEL_BIT;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DROP_HORIZON: sb.drop_horizon = value;
      REG_ECN_HORIZON:  sb.ecn_horizon  = value;
      default: ;
    endcase
  endtask

  // Horizons may only change while nothing is in flight, so wait for every
  // expected result. Every request yields a result, so an empty queue means
  // the block is idle. The first edge lets the monitor note a request that
  // was accepted at the edge this task is entered on.
  task automatic wait_drained();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Random traffic. Most requests hit a handful of flows while the wall
  // clock creeps forward, so flows build a backlog and the lead over the
  // current time climbs into the marking and dropping bands. The rest is
  // full-range noise that reaches every bit of every field and the wrap
  // cases near the top of the time range.
  task automatic run_phase(input int unsigned idle_pct, input int unsigned count);
    logic [FLOW_IDX_W-1:0] flow;
    logic [LEN_W-1:0]      len;
    logic [TIME_W-1:0]     pkt_time;
    logic [RATE_W-1:0]     rate;
    logic [DELAY_W-1:0]    delay;
    int unsigned           pick;
    int unsigned           gap;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 70)      flow = FLOW_IDX_W'($urandom_range(7));
      else if (pick < 90) flow = FLOW_IDX_W'($urandom_range(FLOW_COUNT - 1));
      else                flow = ($urandom_range(1) != 0) ? '1 : '0;

      pick = $urandom_range(99);
      if (pick < 85)      wall_ns = wall_ns + 64'($urandom_range(3000));
      else if (pick < 93) wall_ns = {$urandom(), $urandom()};
      else                wall_ns = TIME_MAX - 64'($urandom_range(1000000));

      pick = $urandom_range(99);
      if (pick < 30)      pkt_time = '0;
      else if (pick < 60) pkt_time = wall_ns + 64'($urandom_range(20000));
      else if (pick < 85) pkt_time = wall_ns - 64'($urandom_range(20000));
      else                pkt_time = {$urandom(), $urandom()};

      pick = $urandom_range(99);
      if (pick < 80)      len = LEN_W'($urandom_range(1500, 64));
      else if (pick < 88) len = LEN_W'($urandom());
      else if (pick < 94) len = '0;
      else                len = '1;

      pick = $urandom_range(99);
      if (pick < 5)       rate = '0;
      else if (pick < 60) rate = RATE_W'($urandom_range(200000, 1000));
      else if (pick < 80) rate = RATE_W'($urandom_range(1000, 1));
      else if (pick < 90) rate = RATE_W'($urandom());
      else                rate = '1;

      pick = $urandom_range(99);
      if (pick < 60)      delay = DELAY_W'($urandom_range(1000));
      else if (pick < 70) delay = '0;
      else if (pick < 90) delay = DELAY_W'($urandom());
      else                delay = '1;

      send_request(flow, len, pkt_time, wall_ns, rate, delay);

      // Gaps of up to a little more than one request time let the next
      // request arrive at any point of the block's work.
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(MAX_GAP, 1) : 0;
      if (gap != 0 || n == count - 1)
        start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned idle_pct [PHASE_COUNT];
    logic [63:0] drop_cfg [PHASE_COUNT];
    logic [63:0] ecn_cfg  [PHASE_COUNT];

    // Every input is known from time zero.
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    flow_index_i    <= '0;
    packet_length_i <= '0;
    packet_time_i   <= '0;
    now_time_i      <= '0;
    rate_kbps_i     <= '0;
    delay_us_i      <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    wall_ns          = 64'd1000000;

    // Sender idle rates: 35 percent, then 47, then none at all.
    idle_pct = '{35, 35, 47, 47, 0, 0};
    // Horizon settings, extremes among them: a zero drop horizon drops every
    // backlogged packet, a zero marking horizon marks every one, and all
    // ones in both disables either action.
    drop_cfg = '{64'd2000000000, TIME_MAX, 64'd0, {$urandom(), $urandom()},
                 64'd5000000, TIME_MAX};
    ecn_cfg  = '{64'd1000000, 64'd0, TIME_MAX, {$urandom(), $urandom()},
                 64'($urandom_range(3000000, 1)), TIME_MAX};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The block is clearing its flow store now; the horizons may be set
    // meanwhile, and the first request simply waits for busy to drop.
    write_horizon(REG_DROP_HORIZON, 64'd2000000000);
    write_horizon(REG_ECN_HORIZON, 64'd1000000);

    // Directed requests.
    // A zero rate drops the packet and does not create the flow.
    send_request(10'd5, 16'd1500, 64'd0, 64'd1000, 32'd0, 23'd10);
    // A new flow passes at once; an unset packet time leaves at now.
    send_request(10'd5, 16'd1500, 64'd0, 64'd1000, 32'd1000, 23'd0);
    // The same flow is now backlogged by 1.5 ms, past the marking horizon.
    send_request(10'd5, 16'd1500, 64'd0, 64'd1000, 32'd1000, 23'd10);
    // A huge serialization delay pushes the lead past the drop horizon,
    // and the stored time must stay as it was.
    send_request(10'd5, 16'd65535, 64'd0, 64'd2000, 32'd1, 23'd0);
    // A packet time far ahead of the backlog keeps its own time.
    send_request(10'd5, 16'd64, 64'd5000000000, 64'd3000, 32'd1000000, 23'd7);
    // Every field at its top value; the added delay wraps the result.
    send_request('1, '1, TIME_MAX, TIME_MAX, '1, '1);
    // The stored time plus the serialization delay wraps to a small value,
    // which is no later than now, so the packet passes on the first path.
    send_request('1, '1, 64'd0, 64'd1000, '1, 23'd0);
    // Zero length and zero times: the departure is zero.
    send_request(10'd0, 16'd0, 64'd0, 64'd0, 32'd1, 23'd0);
    send_request(10'd0, 16'd0, 64'd0, 64'd0, 32'd1, 23'd0);
    // Unset packet time with the largest added delay.
    send_request(10'd0, 16'd0, 64'd0, 64'd0, 32'd1, '1);
    // Packet time ahead of and behind the current time on a new flow.
    send_request(10'd2, 16'd1500, 64'd123456789, 64'd100, 32'd5000, 23'd1);
    send_request(10'd2, 16'd1500, 64'd50, 64'd200000000, 32'd5000, 23'd1);
    // A short backlog well inside the marking horizon.
    send_request(10'd3, 16'd100, 64'd0, 64'd10, 32'd1000000, 23'd0);
    send_request(10'd3, 16'd100, 64'd0, 64'd10, 32'd1000000, 23'd0);
    // Alternating bit patterns on every field, then their complements.
    send_request(10'h2AA, 16'hAAAA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                 32'h5555_5555, 23'h2A_AAAA);
    send_request(10'h155, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                 32'hAAAA_AAAA, 23'h55_5555);
    send_request(10'h155, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                 32'hAAAA_AAAA, 23'h55_5555);
    start <= 1'b0;

    // Random phases, each under its own horizon setting.
    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      wait_drained();
      write_horizon(REG_DROP_HORIZON, drop_cfg[p]);
      write_horizon(REG_ECN_HORIZON, ecn_cfg[p]);
      run_phase(idle_pct[p], REQS_PER_PHASE);
    end

    // Let the last results come in, then a few more cycles to catch any
    // stray strobe.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.pending() != 0)
      sb.report_mismatch("requests left without result", 64'(sb.pending()), '0);
    if (sb.error_count == 0)
      $display("per_flow_departure_time_pacer_unit: match");
    else
      $display("per_flow_departure_time_pacer_unit: mismatch");
    $finish;
  end

endmodule
